// ===== src/fwq_pkg.sv =====
// ----------------------------------------------------------------------------
// Futex wait table package
// Sizes, codes, the key hash and the controller/datapath link types.
// ----------------------------------------------------------------------------
package fwq_pkg;

  localparam int HASH_BUCKETS = 64;
  localparam int POOL_ENTRIES = 256;
  localparam int WAITER_SLOTS = 64;
  localparam int WAKE_CAP     = 64;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int WID_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam int KEY_PAIR_W = 2 * KEY_W;

  localparam int E_IDX_W = $clog2(POOL_ENTRIES);
  localparam int E_W     = E_IDX_W + 1;
  localparam int B_W     = $clog2(HASH_BUCKETS);
  localparam int WS_IDX_W = $clog2(WAITER_SLOTS);
  localparam int WS_W     = WS_IDX_W + 1;

  localparam logic [E_W-1:0]  NIL_ENTRY  = E_W'(POOL_ENTRIES);
  localparam logic [WS_W-1:0] NIL_WAITER = WS_W'(WAITER_SLOTS);

  localparam logic [FUNC_W-1:0] FUNC_WAIT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WAKE = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_NO_ENTRY  = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef struct packed {
    logic accept;
    logic init_wr;
    logic check;
    logic head;
    logic cmp;
    logic set_full;
    logic alloc_rd;
    logic alloc;
    logic push;
    logic wh_load;
    logic popchk;
    logic pop_out;
    logic rel_unlink;
    logic rel_free;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic req_fire;
    logic err;
    logic is_wake;
    logic cur_nil;
    logic match;
    logic free_nil;
    logic head_nil;
    logic stop;
    logic cnt_zero;
    logic out_free;
  } stat_t;

  function automatic logic [B_W-1:0] bucket_of(input logic [KEY_W-1:0] sp,
                                               input logic [KEY_W-1:0] ad);
    logic [KEY_W-1:0] h;
    h = sp ^ (ad >> 2) ^ (ad >> 14);
    return h[B_W-1:0];
  endfunction

endpackage

// ===== src/fwq_if.sv =====
// ----------------------------------------------------------------------------
// Futex wait table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fwq_req_if;
  logic                         valid;
  logic                         ready;
  logic [fwq_pkg::FUNC_W-1:0]   func;
  logic [fwq_pkg::KEY_W-1:0]    space_id;
  logic [fwq_pkg::KEY_W-1:0]    word_addr;
  logic                         addr_ok;
  logic [fwq_pkg::VALUE_W-1:0]  current_value;
  logic [fwq_pkg::VALUE_W-1:0]  operand;
  logic [fwq_pkg::WID_W-1:0]    waiter_id;

  modport source(output valid, func, space_id, word_addr, addr_ok, current_value,
                 operand, waiter_id, input ready);
  modport sink(input valid, func, space_id, word_addr, addr_ok, current_value,
               operand, waiter_id, output ready);
endinterface

interface fwq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fwq_pkg::STATUS_W-1:0]  status;
  logic                          woken_valid;
  logic [fwq_pkg::WID_W-1:0]     woken_id;
  logic [fwq_pkg::COUNT_W-1:0]   woken_count;
  logic                          last;

  modport source(output valid, status, woken_valid, woken_id, woken_count, last,
                 input ready);
  modport sink(input valid, status, woken_valid, woken_id, woken_count, last,
               output ready);
endinterface

// ===== src/fwq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fwq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Futex wait table controller
// Sequences init, chain walk, allocate, push, pop and release steps.
// ----------------------------------------------------------------------------
module fwq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  fwq_pkg::stat_t st,
  output fwq_pkg::cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_INIT   = 18'h00001,
    S_IDLE   = 18'h00002,
    S_CHECK  = 18'h00004,
    S_HEAD   = 18'h00008,
    S_WALK   = 18'h00010,
    S_CMP    = 18'h00020,
    S_ARD    = 18'h00040,
    S_ALLOC  = 18'h00080,
    S_WRD    = 18'h00100,
    S_PUSH   = 18'h00200,
    S_WHD    = 18'h00400,
    S_POPCHK = 18'h00800,
    S_POP    = 18'h01000,
    S_POPNX  = 18'h02000,
    S_REL1   = 18'h04000,
    S_REL2   = 18'h08000,
    S_REL3   = 18'h10000,
    S_EMIT   = 18'h20000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (st.req_fire) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.err ? S_EMIT : S_HEAD;
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!st.cur_nil) begin
          state_next = S_CMP;
        end else if (st.is_wake) begin
          state_next = S_EMIT;
        end else if (st.free_nil) begin
          cmd.set_full = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_ARD;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = st.match ? S_WRD : S_WALK;
      end
      S_ARD: begin
        cmd.alloc_rd = 1'b1;
        state_next   = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_EMIT;
      end
      S_WRD: begin
        state_next = st.is_wake ? S_WHD : S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_EMIT;
      end
      S_WHD: begin
        cmd.wh_load = 1'b1;
        state_next  = S_POPCHK;
      end
      S_POPCHK: begin
        cmd.popchk = 1'b1;
        if (!st.head_nil && !st.stop) begin
          state_next = S_POP;
        end else if (st.head_nil) begin
          state_next = S_REL1;
        end else begin
          state_next = st.cnt_zero ? S_EMIT : S_IDLE;
        end
      end
      S_POP: begin
        state_next = S_POPNX;
      end
      S_POPNX: begin
        cmd.pop_out = 1'b1;
        if (st.out_free) state_next = S_POPCHK;
      end
      S_REL1: begin
        state_next = S_REL2;
      end
      S_REL2: begin
        cmd.rel_unlink = 1'b1;
        state_next     = S_REL3;
      end
      S_REL3: begin
        cmd.rel_free = 1'b1;
        state_next   = st.cnt_zero ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== src/fwq_dp.sv =====
// ----------------------------------------------------------------------------
// Futex wait table datapath
// Request registers, entry and waiter memories, free pool and result register.
// ----------------------------------------------------------------------------
module fwq_dp (
  input  logic           clk,
  input  logic           rst,
  input  fwq_pkg::cmd_t  cmd,
  output fwq_pkg::stat_t st,
  fwq_req_if.sink        req,
  fwq_rsp_if.source      rsp
);

  // request
  logic [fwq_pkg::FUNC_W-1:0]  r_func;
  logic [fwq_pkg::KEY_W-1:0]   r_space;
  logic [fwq_pkg::KEY_W-1:0]   r_addr;
  logic                        r_ok;
  logic [fwq_pkg::VALUE_W-1:0] r_cur;
  logic [fwq_pkg::VALUE_W-1:0] r_opnd;
  logic [fwq_pkg::WID_W-1:0]   r_wid;

  // walk and pool
  logic [fwq_pkg::E_W-1:0]     cur, prev, headb, free_head;
  logic [fwq_pkg::WS_W-1:0]    head_w;
  logic [fwq_pkg::COUNT_W-1:0] cnt;
  fwq_pkg::status_t            res;
  logic [fwq_pkg::E_IDX_W-1:0] init_cnt;
  logic [fwq_pkg::WAITER_SLOTS-1:0] busy;

  // result register
  logic                        o_valid;
  fwq_pkg::status_t            o_status;
  logic                        o_wv;
  logic [fwq_pkg::WID_W-1:0]   o_wid;
  logic [fwq_pkg::COUNT_W-1:0] o_cnt;
  logic                        o_last;

  logic [fwq_pkg::B_W-1:0]     bkt;
  logic [fwq_pkg::WS_IDX_W-1:0] wslot;
  logic                        wid_bad;
  fwq_pkg::status_t            err_code;
  logic [fwq_pkg::COUNT_W-1:0] n_pop;
  logic                        pop_last;
  logic                        out_free;
  logic                        req_fire;

  // memories
  logic [fwq_pkg::KEY_PAIR_W-1:0] key_rdata, key_wdata;
  logic                          key_we;
  logic [fwq_pkg::E_W-1:0]       en_rdata, en_wdata;
  logic [fwq_pkg::E_IDX_W-1:0]   en_waddr, en_raddr;
  logic                          en_we;
  logic [fwq_pkg::WS_W-1:0]      wh_rdata, wh_wdata;
  logic                          wh_we;
  logic [fwq_pkg::E_W-1:0]       bh_rdata, bh_wdata;
  logic [fwq_pkg::B_W-1:0]       bh_waddr;
  logic                          bh_we;
  logic [fwq_pkg::WS_W-1:0]      wn_rdata, wn_wdata;
  logic                          wn_we;

  assign bkt      = fwq_pkg::bucket_of(r_space, r_addr);
  assign wslot    = r_wid[fwq_pkg::WS_IDX_W-1:0];
  assign wid_bad  = ({1'b0, r_wid} >= (fwq_pkg::WID_W + 1)'(fwq_pkg::WAITER_SLOTS));
  assign out_free = !o_valid || rsp.ready;
  assign req_fire = req.valid && req.ready;
  assign req.ready = cmd.accept;
  assign n_pop    = cnt + 1'b1;
  assign pop_last = (wn_rdata == fwq_pkg::NIL_WAITER)
                 || ({(fwq_pkg::VALUE_W - fwq_pkg::COUNT_W)'(0), n_pop} >= r_opnd)
                 || (n_pop == fwq_pkg::COUNT_W'(fwq_pkg::WAKE_CAP));

  always_comb begin
    if (!r_ok) begin
      err_code = fwq_pkg::ST_BAD_ADDR;
    end else if (r_func != fwq_pkg::FUNC_WAIT && r_func != fwq_pkg::FUNC_WAKE) begin
      err_code = fwq_pkg::ST_INVALID;
    end else if (r_func == fwq_pkg::FUNC_WAIT && r_cur != r_opnd) begin
      err_code = fwq_pkg::ST_MISMATCH;
    end else if (r_func == fwq_pkg::FUNC_WAIT && (wid_bad || busy[wslot])) begin
      err_code = fwq_pkg::ST_INVALID;
    end else begin
      err_code = fwq_pkg::ST_OK;
    end
  end

  always_comb begin
    st.init_done = (init_cnt == fwq_pkg::E_IDX_W'(fwq_pkg::POOL_ENTRIES - 1));
    st.req_fire  = req_fire;
    st.err       = (err_code != fwq_pkg::ST_OK);
    st.is_wake   = (r_func == fwq_pkg::FUNC_WAKE);
    st.cur_nil   = (cur == fwq_pkg::NIL_ENTRY);
    st.match     = (key_rdata == {r_space, r_addr});
    st.free_nil  = (free_head == fwq_pkg::NIL_ENTRY);
    st.head_nil  = (head_w == fwq_pkg::NIL_WAITER);
    st.stop      = ({(fwq_pkg::VALUE_W - fwq_pkg::COUNT_W)'(0), cnt} >= r_opnd)
                || (cnt == fwq_pkg::COUNT_W'(fwq_pkg::WAKE_CAP));
    st.cnt_zero  = (cnt == '0);
    st.out_free  = out_free;
  end

  // memory write ports
  always_comb begin
    key_we   = cmd.alloc;
    key_wdata = {r_space, r_addr};

    en_we    = 1'b0;
    en_waddr = cur[fwq_pkg::E_IDX_W-1:0];
    en_wdata = headb;
    if (cmd.init_wr) begin
      en_we    = 1'b1;
      en_waddr = init_cnt;
      en_wdata = (init_cnt == '0) ? fwq_pkg::NIL_ENTRY : ({1'b0, init_cnt} - 1'b1);
    end else if (cmd.alloc) begin
      en_we = 1'b1;
    end else if (cmd.rel_unlink && prev != fwq_pkg::NIL_ENTRY) begin
      en_we    = 1'b1;
      en_waddr = prev[fwq_pkg::E_IDX_W-1:0];
      en_wdata = en_rdata;
    end else if (cmd.rel_free) begin
      en_we    = 1'b1;
      en_wdata = free_head;
    end

    bh_we    = 1'b0;
    bh_waddr = bkt;
    bh_wdata = cur;
    if (cmd.init_wr) begin
      bh_we    = ({1'b0, init_cnt} < fwq_pkg::E_W'(fwq_pkg::HASH_BUCKETS));
      bh_waddr = init_cnt[fwq_pkg::B_W-1:0];
      bh_wdata = fwq_pkg::NIL_ENTRY;
    end else if (cmd.alloc) begin
      bh_we = 1'b1;
    end else if (cmd.rel_unlink && prev == fwq_pkg::NIL_ENTRY) begin
      bh_we    = 1'b1;
      bh_wdata = en_rdata;
    end

    wh_we    = cmd.alloc || cmd.push || cmd.popchk;
    wh_wdata = cmd.popchk ? head_w : {1'b0, wslot};

    wn_we    = cmd.alloc || cmd.push;
    wn_wdata = cmd.alloc ? fwq_pkg::NIL_WAITER : wh_rdata;
  end

  assign en_raddr = cmd.alloc_rd ? free_head[fwq_pkg::E_IDX_W-1:0]
                                 : cur[fwq_pkg::E_IDX_W-1:0];

  fwq_ram #(.WIDTH(fwq_pkg::KEY_PAIR_W), .DEPTH(fwq_pkg::POOL_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(cur[fwq_pkg::E_IDX_W-1:0]), .wdata(key_wdata),
    .raddr(cur[fwq_pkg::E_IDX_W-1:0]), .rdata(key_rdata));

  fwq_ram #(.WIDTH(fwq_pkg::E_W), .DEPTH(fwq_pkg::POOL_ENTRIES)) u_enext (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .raddr(en_raddr), .rdata(en_rdata));

  fwq_ram #(.WIDTH(fwq_pkg::WS_W), .DEPTH(fwq_pkg::POOL_ENTRIES)) u_whead (
    .clk(clk), .we(wh_we), .waddr(cur[fwq_pkg::E_IDX_W-1:0]), .wdata(wh_wdata),
    .raddr(cur[fwq_pkg::E_IDX_W-1:0]), .rdata(wh_rdata));

  fwq_ram #(.WIDTH(fwq_pkg::E_W), .DEPTH(fwq_pkg::HASH_BUCKETS)) u_bhead (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bkt), .rdata(bh_rdata));

  fwq_ram #(.WIDTH(fwq_pkg::WS_W), .DEPTH(fwq_pkg::WAITER_SLOTS)) u_wnext (
    .clk(clk), .we(wn_we), .waddr(wslot), .wdata(wn_wdata),
    .raddr(head_w[fwq_pkg::WS_IDX_W-1:0]), .rdata(wn_rdata));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt  <= '0;
      free_head <= fwq_pkg::E_W'(fwq_pkg::POOL_ENTRIES - 1);
      busy      <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (cmd.init_wr) init_cnt <= init_cnt + 1'b1;
      if (cmd.alloc) begin
        free_head   <= en_rdata;
        busy[wslot] <= 1'b1;
      end
      if (cmd.push) busy[wslot] <= 1'b1;
      if (cmd.rel_free) free_head <= cur;
      if (cmd.pop_out && out_free) begin
        busy[head_w[fwq_pkg::WS_IDX_W-1:0]] <= 1'b0;
      end
      if ((cmd.pop_out || cmd.emit) && out_free) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      r_func  <= req.func;
      r_space <= req.space_id;
      r_addr  <= req.word_addr;
      r_ok    <= req.addr_ok;
      r_cur   <= req.current_value;
      r_opnd  <= req.operand;
      r_wid   <= req.waiter_id;
    end
    if (cmd.check) res <= err_code;
    if (cmd.set_full) res <= fwq_pkg::ST_NO_ENTRY;
    if (cmd.head) begin
      cur   <= bh_rdata;
      headb <= bh_rdata;
      prev  <= fwq_pkg::NIL_ENTRY;
    end
    if (cmd.cmp && !st.match) begin
      prev <= cur;
      cur  <= en_rdata;
    end
    if (cmd.alloc_rd) cur <= free_head;
    if (cmd.wh_load) begin
      head_w <= wh_rdata;
      cnt    <= '0;
    end
    if (cmd.pop_out && out_free) begin
      head_w   <= wn_rdata;
      cnt      <= n_pop;
      o_status <= fwq_pkg::ST_OK;
      o_wv     <= 1'b1;
      o_wid    <= head_w[fwq_pkg::WID_W-1:0];
      o_cnt    <= n_pop;
      o_last   <= pop_last;
    end
    if (cmd.emit && out_free) begin
      o_status <= res;
      o_wv     <= 1'b0;
      o_wid    <= '0;
      o_cnt    <= '0;
      o_last   <= 1'b1;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.woken_valid = o_wv;
  assign rsp.woken_id    = o_wid;
  assign rsp.woken_count = o_cnt;
  assign rsp.last        = o_last;

endmodule

// ===== src/futex_wait_queue_table.sv =====
// An error result is loaded after the request transfer via the check and emit
// states; a wait passes the head state and a walk and compare state per chain
// entry in the bucket memory walk. A wake passes the pop check, pop and pop-next
// states per woken waiter (waiter link memory read) and release states to free
// the entry. One request is in flight at a time. After reset an init pass over
// all pool entries builds the free chain and clears the buckets, req.ready low.
// ----------------------------------------------------------------------------
// Futex wait table
// Hashed wait queues with a shared entry pool and per-entry waiter stacks.
// ----------------------------------------------------------------------------
module futex_wait_queue_table (
  input logic       clk,
  input logic       rst,
  fwq_req_if.sink   req,
  fwq_rsp_if.source rsp
);

  fwq_pkg::cmd_t  cmd;
  fwq_pkg::stat_t st;

  fwq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .cmd(cmd));

  fwq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .req(req), .rsp(rsp));

endmodule

// ===== src/fwq_checker.sv =====
// ----------------------------------------------------------------------------
// Futex wait table checker
// Port-level properties of the request and response streams, bound to the top level.
// ----------------------------------------------------------------------------
module fwq_props (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [fwq_pkg::STATUS_W-1:0] rsp_status,
  input logic                         rsp_woken_valid,
  input logic [fwq_pkg::WID_W-1:0]    rsp_woken_id,
  input logic [fwq_pkg::COUNT_W-1:0]  rsp_woken_count,
  input logic                         rsp_last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_woken_id)
      && $stable(rsp_woken_count) && $stable(rsp_last))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != fwq_pkg::ST_OK |-> rsp_last && !rsp_woken_valid)
    else $error("error result not single");

  a_woken_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_woken_valid |-> rsp_woken_count != '0
      && rsp_status == fwq_pkg::ST_OK)
    else $error("woken result without count");

  a_plain_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_woken_valid |-> rsp_last && rsp_woken_count == '0
      && rsp_woken_id == '0)
    else $error("plain result malformed");

endmodule

bind futex_wait_queue_table fwq_props u_fwq_props (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_woken_valid(rsp.woken_valid),
  .rsp_woken_id(rsp.woken_id), .rsp_woken_count(rsp.woken_count),
  .rsp_last(rsp.last)
);
